// ===== rtl/core/cqa_pkg.sv =====
`default_nettype none

package cqa_pkg;

  // table geometry
  localparam int MAX_CLIENTS = 64;
  localparam int SLOT_W      = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;

  // field widths fixed by the interface
  localparam int KIND_W   = 4;
  localparam int CLIENT_W = 6;
  localparam int AMOUNT_W = 64;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_REGISTER    = 4'd0,
    KIND_UNREGISTER  = 4'd1,
    KIND_ALLOC       = 4'd2,
    KIND_FREE        = 4'd3,
    KIND_KERNEL_REQ  = 4'd4,
    KIND_KERNEL_DONE = 4'd5,
    KIND_COPY_REQ    = 4'd6,
    KIND_COPY_DONE   = 4'd7
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_APPROVED = 2'd0,
    STAT_REJECTED = 2'd1,
    STAT_DONE     = 2'd2
  } status_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_LIMIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTEXT_OVERHEAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_LIMIT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COPY_LIMIT       = 2'd3;

  // controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

  // one slot of the client table
  typedef struct packed {
    logic [AMOUNT_W-1:0] bytes_used;
    logic [CNT_W-1:0]    kernels;
    logic [CNT_W-1:0]    copies;
  } slot_rec_t;

endpackage

`default_nettype wire

// ===== rtl/core/cqa_ctrl.sv =====
`default_nettype none

module cqa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  output cqa_pkg::cmd_t      cmd
);
  import cqa_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy        = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = start;
      end
      S_EXEC: begin
        busy     = 1'b1;
        cmd.exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/cqa_dpath.sv =====
`default_nettype none

module cqa_dpath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire cqa_pkg::cmd_t                  cmd,
  input  wire logic [cqa_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [cqa_pkg::CLIENT_W-1:0]   in_client,
  input  wire logic [cqa_pkg::AMOUNT_W-1:0]   in_amount,
  input  wire logic                           cfg_wr_en,
  input  wire logic [cqa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cqa_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                                out_valid,
  output logic [cqa_pkg::STATUS_W-1:0]        out_status,
  output logic signed [0:0]                   out_result_code
);
  import cqa_pkg::*;

  // configuration registers
  logic [AMOUNT_W-1:0] mem_limit_r;
  logic [AMOUNT_W-1:0] ctx_ovh_r;
  logic [CNT_W-1:0]    kern_limit_r;
  logic [CNT_W-1:0]    copy_limit_r;

  // captured request
  logic [KIND_W-1:0]   kind_r;
  logic [SLOT_W-1:0]   slot_r;
  logic                inside_r;
  logic [AMOUNT_W-1:0] amount_r;
  slot_rec_t           rd_r;

  // table, valid bits and totals
  slot_rec_t             tbl_mem [MAX_CLIENTS];
  logic [MAX_CLIENTS-1:0] slot_valid_r;
  logic [CNT_W-1:0]      tot_kern_r;
  logic [CNT_W-1:0]      tot_kern_nxt;
  logic [CNT_W-1:0]      tot_copy_r;
  logic [CNT_W-1:0]      tot_copy_nxt;

  // result registers
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;

  // execute-cycle decisions
  logic                hit;
  logic                wr_en;
  slot_rec_t           wr_data;
  logic                vset;
  logic                vclr;
  logic                emit;
  status_t             stat;
  logic [AMOUNT_W:0]   sum;
  logic [AMOUNT_W:0]   diff;
  logic [SLOT_W-1:0]   in_slot;

  assign in_slot = SLOT_W'(in_client);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_limit_r  <= '0;
      ctx_ovh_r    <= '0;
      kern_limit_r <= '0;
      copy_limit_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MEMORY_LIMIT:     mem_limit_r  <= cfg_data;
        CFG_CONTEXT_OVERHEAD: ctx_ovh_r    <= cfg_data;
        CFG_KERNEL_LIMIT:     kern_limit_r <= cfg_data[CNT_W-1:0];
        CFG_COPY_LIMIT:       copy_limit_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r   <= in_kind;
      slot_r   <= in_slot;
      inside_r <= (32'(in_client) < MAX_CLIENTS);
      amount_r <= in_amount;
    end
  end

  // table memory, registered read at capture
  always_ff @(posedge clk) begin
    if (cmd.capture) rd_r <= tbl_mem[in_slot];
    if (wr_en) tbl_mem[slot_r] <= wr_data;
  end

  // request evaluation
  always_comb begin
    hit          = inside_r && slot_valid_r[slot_r];
    wr_en        = 1'b0;
    wr_data      = rd_r;
    vset         = 1'b0;
    vclr         = 1'b0;
    emit         = 1'b0;
    stat         = STAT_REJECTED;
    tot_kern_nxt = tot_kern_r;
    tot_copy_nxt = tot_copy_r;
    sum  = {1'b0, rd_r.bytes_used} + {1'b0, amount_r};
    diff = {1'b0, rd_r.bytes_used} - {1'b0, amount_r};

    unique case (kind_r)
      KIND_REGISTER: begin
        if (inside_r) begin
          wr_en              = 1'b1;
          vset               = 1'b1;
          wr_data.bytes_used = ctx_ovh_r;
          if (!hit) begin
            wr_data.kernels = '0;
            wr_data.copies  = '0;
          end
        end
      end
      KIND_UNREGISTER: begin
        if (hit) begin
          tot_kern_nxt = tot_kern_r - rd_r.kernels;
          tot_copy_nxt = tot_copy_r - rd_r.copies;
          wr_en        = 1'b1;
          wr_data      = '0;
          vclr         = 1'b1;
        end
      end
      KIND_ALLOC: begin
        emit = 1'b1;
        if (hit && !sum[AMOUNT_W] &&
            (mem_limit_r == '0 || sum[AMOUNT_W-1:0] <= mem_limit_r)) begin
          stat               = STAT_APPROVED;
          wr_en              = 1'b1;
          wr_data.bytes_used = sum[AMOUNT_W-1:0];
        end
      end
      KIND_FREE: begin
        emit = 1'b1;
        if (hit) begin
          stat  = STAT_DONE;
          wr_en = 1'b1;
          // free the amount when it leaves more than the overhead, else drop to it
          if (!diff[AMOUNT_W] && diff[AMOUNT_W-1:0] > ctx_ovh_r) begin
            wr_data.bytes_used = diff[AMOUNT_W-1:0];
          end else if (rd_r.bytes_used > ctx_ovh_r) begin
            wr_data.bytes_used = ctx_ovh_r;
          end
        end
      end
      KIND_KERNEL_REQ: begin
        emit = 1'b1;
        if (hit && tot_kern_r < kern_limit_r && tot_kern_r != CNT_MAX &&
            rd_r.kernels != CNT_MAX) begin
          stat            = STAT_APPROVED;
          wr_en           = 1'b1;
          wr_data.kernels = rd_r.kernels + 1'b1;
          tot_kern_nxt    = tot_kern_r + 1'b1;
        end
      end
      KIND_KERNEL_DONE: begin
        emit = 1'b1;
        if (hit) begin
          stat = STAT_DONE;
          if (rd_r.kernels != '0) begin
            wr_en           = 1'b1;
            wr_data.kernels = rd_r.kernels - 1'b1;
            if (tot_kern_r != '0) tot_kern_nxt = tot_kern_r - 1'b1;
          end
        end
      end
      KIND_COPY_REQ: begin
        emit = 1'b1;
        if (hit && (copy_limit_r == '0 || tot_copy_r < copy_limit_r) &&
            tot_copy_r != CNT_MAX && rd_r.copies != CNT_MAX) begin
          stat           = STAT_APPROVED;
          wr_en          = 1'b1;
          wr_data.copies = rd_r.copies + 1'b1;
          tot_copy_nxt   = tot_copy_r + 1'b1;
        end
      end
      KIND_COPY_DONE: begin
        emit = 1'b1;
        if (hit) begin
          stat = STAT_DONE;
          if (rd_r.copies != '0) begin
            wr_en          = 1'b1;
            wr_data.copies = rd_r.copies - 1'b1;
            if (tot_copy_r != '0) tot_copy_nxt = tot_copy_r - 1'b1;
          end
        end
      end
      default: begin
        emit = 1'b1;
      end
    endcase

    // nothing changes outside the execute cycle
    if (!cmd.exec) begin
      wr_en        = 1'b0;
      vset         = 1'b0;
      vclr         = 1'b0;
      emit         = 1'b0;
      tot_kern_nxt = tot_kern_r;
      tot_copy_nxt = tot_copy_r;
    end
  end

  // valid bits and running totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      tot_kern_r   <= '0;
      tot_copy_r   <= '0;
    end else begin
      if (vset) slot_valid_r[slot_r] <= 1'b1;
      if (vclr) slot_valid_r[slot_r] <= 1'b0;
      tot_kern_r <= tot_kern_nxt;
      tot_copy_r <= tot_copy_nxt;
    end
  end

  // result strobe and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_status_r <= stat;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_code = (out_status_r == STAT_REJECTED) ? 1'sb1 : 1'sb0;

endmodule

`default_nettype wire

// ===== rtl/core/client_quota_admission_unit.sv =====
`default_nettype none

// Client quota admission unit for a shared accelerator.
// Command channel: drive in_kind, in_client and in_amount with start high; the
// transaction is taken at the rising edge where start is high and busy is low.
// Each transaction first reads the client's table slot from the single-port
// table memory as it is taken, then decides and writes back in the execute
// state; busy is high in that state, so no new transaction is taken there.
// Result channel: out_valid is high for exactly one cycle, the cycle after the
// execute cycle, with out_status and out_result_code; register and unregister
// produce no result. The receiver cannot stall, so results must be taken as
// they appear; the unit already accepts the next command during that cycle.
// Configuration: cfg_wr_en, cfg_index and cfg_data write one register per
// cycle (memory limit, context overhead, kernel limit, copy limit); the user
// must write only while the unit is idle, which the unit does not enforce.
// Reset (rst_n low, synchronous) clears the control and configuration registers,
// the slot valid bits and the kernel and copy totals at once; no clearing pass is needed.
module client_quota_admission_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [cqa_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [cqa_pkg::CLIENT_W-1:0]   in_client,
  input  wire logic [cqa_pkg::AMOUNT_W-1:0]   in_amount,
  input  wire logic                           cfg_wr_en,
  input  wire logic [cqa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cqa_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                                out_valid,
  output logic [cqa_pkg::STATUS_W-1:0]        out_status,
  output logic signed [0:0]                   out_result_code
);
  import cqa_pkg::*;

  cmd_t cmd;

  // sequencer
  cqa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // client table and decision logic
  cqa_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_kind         (in_kind),
    .in_client       (in_client),
    .in_amount       (in_amount),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_result_code (out_result_code)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import cqa_pkg::*;

  localparam int HALF_PERIOD     = 5;
  localparam int DRAIN_CYCLES    = 4;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_CYCLES = 500;
  localparam int PHASES          = 8;
  localparam int PHASE_ITEMS     = 125;
  localparam int COPY_RUN        = 40;
  localparam logic [CLIENT_W-1:0] SAT_CLIENT = 6'd9;
  localparam logic [KIND_W-1:0] KIND_FIRST_UNKNOWN = 4'd8;
  localparam logic [KIND_W-1:0] KIND_LAST_UNKNOWN  = 4'hF;
  localparam logic [AMOUNT_W-1:0] ALL_ONES = {AMOUNT_W{1'b1}};

  // one queued transaction, either a request or a register write
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [KIND_W-1:0]     kind;
    logic [CLIENT_W-1:0]   client;
    logic [AMOUNT_W-1:0]   amount;
  } request_t;

  typedef struct {
    status_t           status;
    logic              code;
    logic [KIND_W-1:0] kind;
    logic [CLIENT_W-1:0] client;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [KIND_W-1:0] in_kind = '0;
  logic [CLIENT_W-1:0] in_client = '0;
  logic [AMOUNT_W-1:0] in_amount = '0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic busy;
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic signed [0:0] out_result_code;

  request_t pending_requests[$];
  verdict_t verdicts_due[$];
  int fault_count = 0;
  int stall_cycles = 0;
  int since_take = 1000;
  int gap_left = 0;
  int burst_left = 0;
  bit in_taken = 1'b0;

  // shadow of the admission table and its settings
  bit                  slot_live [MAX_CLIENTS];
  logic [AMOUNT_W-1:0] slot_bytes [MAX_CLIENTS];
  logic [CNT_W-1:0]    slot_kernels [MAX_CLIENTS];
  logic [CNT_W-1:0]    slot_copies [MAX_CLIENTS];
  logic [CNT_W-1:0]    live_kernels;
  logic [CNT_W-1:0]    live_copies;
  logic [AMOUNT_W-1:0] quota_bytes;
  logic [AMOUNT_W-1:0] charge_bytes;
  logic [CNT_W-1:0]    kernel_cap;
  logic [CNT_W-1:0]    copy_cap;

  client_quota_admission_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_client       (in_client),
    .in_amount       (in_amount),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_result_code (out_result_code)
  );

  always #HALF_PERIOD clk = ~clk;

  task automatic flag_mismatch(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    fault_count++;
  endtask

  task automatic log_verdict(input status_t st, input logic [KIND_W-1:0] kind,
                             input logic [CLIENT_W-1:0] client);
    verdict_t v;
    v.status = st;
    v.code   = (st == STAT_REJECTED);
    v.kind   = kind;
    v.client = client;
    verdicts_due.push_back(v);
  endtask

  // expected outcome of one request, updating the shadow table
  task automatic admit_request(input logic [KIND_W-1:0] kind,
                               input logic [CLIENT_W-1:0] client,
                               input logic [AMOUNT_W-1:0] amount);
    int s;
    logic [AMOUNT_W-1:0] used;
    logic [AMOUNT_W-1:0] extra;
    bit fits;
    bit quota_ok;
    s = int'(client);
    if (kind == KIND_REGISTER) begin
      if (s < MAX_CLIENTS) begin
        if (!slot_live[s]) begin
          slot_kernels[s] = '0;
          slot_copies[s]  = '0;
        end
        slot_live[s]  = 1'b1;
        slot_bytes[s] = charge_bytes;
      end
    end else if (kind == KIND_UNREGISTER) begin
      if (s < MAX_CLIENTS && slot_live[s]) begin
        live_kernels    = live_kernels - slot_kernels[s];
        live_copies     = live_copies - slot_copies[s];
        slot_kernels[s] = '0;
        slot_copies[s]  = '0;
        slot_bytes[s]   = '0;
        slot_live[s]    = 1'b0;
      end
    end else if (s >= MAX_CLIENTS || !slot_live[s]) begin
      log_verdict(STAT_REJECTED, kind, client);
    end else begin
      case (kind)
        KIND_ALLOC: begin
          used     = slot_bytes[s];
          fits     = amount <= ALL_ONES - used;
          quota_ok = quota_bytes == '0 ||
                     (used <= quota_bytes && amount <= quota_bytes - used);
          if (fits && quota_ok) begin
            slot_bytes[s] = used + amount;
            log_verdict(STAT_APPROVED, kind, client);
          end else begin
            log_verdict(STAT_REJECTED, kind, client);
          end
        end
        KIND_FREE: begin
          used  = slot_bytes[s];
          extra = (used > charge_bytes) ? used - charge_bytes : '0;
          slot_bytes[s] = used - ((amount > extra) ? extra : amount);
          log_verdict(STAT_DONE, kind, client);
        end
        KIND_KERNEL_REQ: begin
          if (live_kernels >= kernel_cap || live_kernels == CNT_MAX ||
              slot_kernels[s] == CNT_MAX) begin
            log_verdict(STAT_REJECTED, kind, client);
          end else begin
            slot_kernels[s]++;
            live_kernels++;
            log_verdict(STAT_APPROVED, kind, client);
          end
        end
        KIND_KERNEL_DONE: begin
          if (slot_kernels[s] != '0) begin
            slot_kernels[s]--;
            if (live_kernels != '0) live_kernels--;
          end
          log_verdict(STAT_DONE, kind, client);
        end
        KIND_COPY_REQ: begin
          if ((copy_cap != '0 && live_copies >= copy_cap) || live_copies == CNT_MAX ||
              slot_copies[s] == CNT_MAX) begin
            log_verdict(STAT_REJECTED, kind, client);
          end else begin
            slot_copies[s]++;
            live_copies++;
            log_verdict(STAT_APPROVED, kind, client);
          end
        end
        KIND_COPY_DONE: begin
          if (slot_copies[s] != '0) begin
            slot_copies[s]--;
            if (live_copies != '0) live_copies--;
          end
          log_verdict(STAT_DONE, kind, client);
        end
        default: log_verdict(STAT_REJECTED, kind, client);
      endcase
    end
  endtask

  // stimulus helpers
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // a 16-bit limit with junk in the upper bits of the write data
  function automatic logic [63:0] cap_word(input logic [CNT_W-1:0] v);
    logic [63:0] junk;
    junk = rand64();
    return {junk[63:CNT_W], v};
  endfunction

  task automatic queue_request(input logic [KIND_W-1:0] kind, input logic [CLIENT_W-1:0] client,
                               input logic [AMOUNT_W-1:0] amount);
    request_t r;
    r.is_cfg  = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.kind    = kind;
    r.client  = client;
    r.amount  = amount;
    pending_requests.push_back(r);
  endtask

  task automatic queue_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    request_t r;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    r.kind    = '0;
    r.client  = '0;
    r.amount  = '0;
    pending_requests.push_back(r);
  endtask

  function automatic logic [63:0] pick_cap();
    logic [CNT_W-1:0] v;
    case ($urandom_range(0, 4))
      0:       v = '0;
      1:       v = CNT_MAX;
      2:       v = 16'd1;
      default: v = CNT_W'($urandom_range(2, 8));
    endcase
    return cap_word(v);
  endfunction

  function automatic logic [63:0] pick_quota();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return rand64();
      default: return 64'($urandom_range(1, 20000));
    endcase
  endfunction

  function automatic logic [63:0] pick_charge();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return rand64();
      default: return 64'($urandom_range(0, 3000));
    endcase
  endfunction

  function automatic logic [63:0] pick_amount(input logic [63:0] quota);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return rand64();
      3:       return quota;
      4:       return quota - 64'($urandom_range(0, 100));
      default: return 64'($urandom_range(0, 4096));
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return KIND_ALLOC;
    if (r < 45) return KIND_FREE;
    if (r < 60) return KIND_KERNEL_REQ;
    if (r < 70) return KIND_KERNEL_DONE;
    if (r < 85) return KIND_COPY_REQ;
    if (r < 95) return KIND_COPY_DONE;
    return KIND_REGISTER;
  endfunction

  // driver: at most one new transaction or register write per falling edge
  always @(negedge clk) begin : drive
    logic                  nx_start;
    logic                  nx_wr;
    logic [CFG_IDX_W-1:0]  nx_idx;
    logic [CFG_DATA_W-1:0] nx_data;
    logic [KIND_W-1:0]     nx_kind;
    logic [CLIENT_W-1:0]   nx_client;
    logic [AMOUNT_W-1:0]   nx_amount;
    int r;
    if (rst_n) begin
      nx_start  = start;
      nx_wr     = 1'b0;
      nx_idx    = cfg_index;
      nx_data   = cfg_data;
      nx_kind   = in_kind;
      nx_client = in_client;
      nx_amount = in_amount;
      if (!(start && !in_taken)) begin
        nx_start = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() > 0) begin
          if (pending_requests[0].is_cfg) begin
            // settings change only once the unit has drained
            if (verdicts_due.size() == 0 && !busy && since_take >= DRAIN_CYCLES) begin
              nx_wr   = 1'b1;
              nx_idx  = pending_requests[0].reg_idx;
              nx_data = pending_requests[0].reg_val;
              void'(pending_requests.pop_front());
            end
          end else begin
            nx_start  = 1'b1;
            nx_kind   = pending_requests[0].kind;
            nx_client = pending_requests[0].client;
            nx_amount = pending_requests[0].amount;
            void'(pending_requests.pop_front());
            // gap before the next transaction: mostly short, a few long, some bursts
            r = $urandom_range(0, 99);
            if (burst_left > 0) begin
              burst_left--;
              gap_left = 0;
            end else if (r < 3) begin
              burst_left = $urandom_range(20, 60);
              gap_left   = 0;
            end else if (r < 50) begin
              gap_left = 0;
            end else if (r < 85) begin
              gap_left = $urandom_range(1, 3);
            end else if (r < 95) begin
              gap_left = $urandom_range(4, 8);
            end else begin
              gap_left = $urandom_range(10, 40);
            end
          end
        end
      end
      start     <= nx_start;
      cfg_wr_en <= nx_wr;
      cfg_index <= nx_idx;
      cfg_data  <= nx_data;
      in_kind   <= nx_kind;
      in_client <= nx_client;
      in_amount <= nx_amount;
    end
  end

  // monitor: check results, track settings, predict accepted requests
  always @(posedge clk) begin : observe
    verdict_t due;
    if (!rst_n) begin
      for (int s = 0; s < MAX_CLIENTS; s++) begin
        slot_live[s]    = 1'b0;
        slot_bytes[s]   = '0;
        slot_kernels[s] = '0;
        slot_copies[s]  = '0;
      end
      live_kernels = '0;
      live_copies  = '0;
      quota_bytes  = '0;
      charge_bytes = '0;
      kernel_cap   = '0;
      copy_cap     = '0;
      in_taken     = 1'b0;
      stall_cycles = 0;
      since_take   = 1000;
    end else begin
      in_taken = 1'b0;
      stall_cycles++;
      // result transaction against the oldest expectation
      if (out_valid) begin
        stall_cycles = 0;
        if (verdicts_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result status=%0d code=%0d",
                                  out_status, out_result_code));
        end else begin
          due = verdicts_due.pop_front();
          if (out_status !== due.status)
            flag_mismatch($sformatf("kind %0d client %0d: status %0d, expected %0d",
                                    due.kind, due.client, out_status, due.status));
          if (out_result_code !== due.code)
            flag_mismatch($sformatf("kind %0d client %0d: result_code %0d, expected %0d",
                                    due.kind, due.client, out_result_code, due.code));
        end
      end
      // register writes
      if (cfg_wr_en) begin
        stall_cycles = 0;
        case (cfg_index)
          CFG_MEMORY_LIMIT:     quota_bytes  = cfg_data;
          CFG_CONTEXT_OVERHEAD: charge_bytes = cfg_data;
          CFG_KERNEL_LIMIT:     kernel_cap   = cfg_data[CNT_W-1:0];
          CFG_COPY_LIMIT:       copy_cap     = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      // request transaction
      if (start && !busy) begin
        stall_cycles = 0;
        in_taken     = 1'b1;
        since_take   = 0;
        admit_request(in_kind, in_client, in_amount);
      end else if (since_take < 1000) begin
        since_take++;
      end
      if (stall_cycles >= WATCHDOG_CYCLES) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [63:0] quota;
    logic [63:0] charge;
    logic [63:0] kcap;
    logic [63:0] ccap;
    logic [CLIENT_W-1:0] who;
    int issued;
    int steps;
    // directed: masking of limits, overflow, overhead floor, limits, re-registration
    queue_setting(CFG_MEMORY_LIMIT, '0);
    queue_setting(CFG_CONTEXT_OVERHEAD, 64'd100);
    queue_setting(CFG_KERNEL_LIMIT, 64'hFFFF_FFFF_FFFF_0002);
    queue_setting(CFG_COPY_LIMIT, 64'h0000_0000_0000_0001);
    queue_request(KIND_ALLOC, 6'd5, 64'd10);
    queue_request(KIND_FIRST_UNKNOWN, 6'd5, '0);
    queue_request(KIND_REGISTER, 6'd0, ALL_ONES);
    queue_request(KIND_ALLOC, 6'd0, ALL_ONES);
    queue_request(KIND_ALLOC, 6'd0, ALL_ONES - 64'd100);
    queue_request(KIND_ALLOC, 6'd0, '0);
    queue_request(KIND_FREE, 6'd0, ALL_ONES);
    queue_request(KIND_FREE, 6'd0, 64'd5);
    repeat (3) queue_request(KIND_KERNEL_REQ, 6'd0, '0);
    repeat (3) queue_request(KIND_KERNEL_DONE, 6'd0, '0);
    queue_request(KIND_COPY_REQ, 6'd0, '0);
    queue_request(KIND_REGISTER, 6'd0, '0);
    queue_request(KIND_COPY_REQ, 6'd0, '0);
    queue_request(KIND_UNREGISTER, 6'd0, '0);
    queue_request(KIND_COPY_DONE, 6'd0, '0);
    queue_request(KIND_UNREGISTER, 6'd5, '0);
    queue_request(KIND_REGISTER, 6'd63, '0);
    queue_request(KIND_COPY_REQ, 6'd63, '0);
    queue_request(KIND_COPY_DONE, 6'd63, '0);
    queue_request(KIND_LAST_UNKNOWN, 6'd63, ALL_ONES);

    // random phases, each under its own settings
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          quota  = ALL_ONES;
          charge = ALL_ONES;
          kcap   = cap_word(CNT_MAX);
          ccap   = cap_word(CNT_MAX);
        end
        1: begin
          quota  = '0;
          charge = '0;
          kcap   = cap_word(16'd0);
          ccap   = cap_word(16'd0);
        end
        2: begin
          quota  = 64'($urandom_range(1, 2000));
          charge = quota + 64'($urandom_range(0, 500));
          kcap   = cap_word(16'd1);
          ccap   = cap_word(16'd1);
        end
        default: begin
          quota  = pick_quota();
          charge = pick_charge();
          kcap   = pick_cap();
          ccap   = pick_cap();
        end
      endcase
      queue_setting(CFG_MEMORY_LIMIT, quota);
      queue_setting(CFG_CONTEXT_OVERHEAD, charge);
      queue_setting(CFG_KERNEL_LIMIT, kcap);
      queue_setting(CFG_COPY_LIMIT, ccap);
      issued = 0;
      while (issued < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 15) begin
          // noise
          queue_request(KIND_W'($urandom_range(0, KIND_LAST_UNKNOWN)),
                        CLIENT_W'($urandom_range(0, 63)), pick_amount(quota));
          issued++;
        end else begin
          // client session: register, a run of requests, maybe unregister
          who = ($urandom_range(0, 4) != 0) ? CLIENT_W'($urandom_range(0, 7))
                                            : CLIENT_W'($urandom_range(0, 63));
          queue_request(KIND_REGISTER, who, rand64());
          steps = $urandom_range(3, 12);
          for (int i = 0; i < steps; i++) queue_request(pick_op(), who, pick_amount(quota));
          issued += steps + 1;
          if ($urandom_range(0, 9) < 3) begin
            queue_request(KIND_UNREGISTER, who, rand64());
            issued++;
          end
        end
      end
    end

    // a long copy run with no copy limit
    queue_setting(CFG_COPY_LIMIT, cap_word(16'd0));
    queue_request(KIND_UNREGISTER, SAT_CLIENT, '0);
    queue_request(KIND_REGISTER, SAT_CLIENT, '0);
    for (int i = 0; i < COPY_RUN; i++) queue_request(KIND_COPY_REQ, SAT_CLIENT, rand64());
    queue_request(KIND_COPY_DONE, SAT_CLIENT, '0);
    queue_request(KIND_COPY_REQ, SAT_CLIENT, '0);
    queue_request(KIND_COPY_REQ, SAT_CLIENT, '0);
    queue_request(KIND_UNREGISTER, SAT_CLIENT, '0);
    queue_request(KIND_COPY_REQ, SAT_CLIENT, '0);

    // reset, then run until everything has been taken and answered
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_requests.size() > 0 || start) @(posedge clk);
    while (verdicts_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (verdicts_due.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", verdicts_due.size()));
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
